@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPL(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(name, clk_sig, rst_sig, ante, cons)

`define ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons)

`endif

`endif

@@ hw/rtl/numdec_pkg.sv @@
// ----------------------------------------------------------------------------
// numdec_pkg
// Shared constants and types of the numeric-to-decimal-text converter.
// ----------------------------------------------------------------------------
package numdec_pkg;

  localparam int VALUE_BITS  = 128;
  localparam int DIGIT_SLOTS = 40;
  localparam int SCALE_MAX   = 38;
  localparam int SCALE_W     = 6;
  localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1);

  localparam int BYTE_STEPS  = (VALUE_BITS + 7) / 8;
  localparam int WREG_W      = BYTE_STEPS * 8;
  localparam int STEP_W      = $clog2(BYTE_STEPS);

  // floor(v / 10) == (v * RECIP10) >> RECIP_SHIFT for every v below 2560
  localparam int RECIP10     = 3277;
  localparam int RECIP_SHIFT = 15;
  localparam int TEN         = 10;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_POINT = 7'h2E;

  typedef struct packed {
    logic       valid;
    logic [3:0] digit;
  } digit_push_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
  } div_stat_t;

  typedef struct packed {
    logic               start;
    logic [CNT_W-1:0]   count;
    logic [SCALE_W-1:0] scale;
    logic               negative;
  } emit_cfg_t;

endpackage

@@ hw/rtl/numdec_div.sv @@
// ----------------------------------------------------------------------------
// numdec_div
// Byte-serial divide by ten: shifts the value through a remainder stage one
// byte per cycle and yields one decimal digit per pass, least significant
// first, until the quotient is zero or every digit slot is filled.
// ----------------------------------------------------------------------------
module numdec_div import numdec_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] magnitude,
  output digit_push_t           push,
  output div_stat_t             stat
);

  logic              busy;
  logic [WREG_W-1:0] work;
  logic [3:0]        rem;
  logic [STEP_W-1:0] step;
  logic              nz;
  logic [CNT_W-1:0]  count;

  logic [11:0] v;
  logic [23:0] prod;
  logic [7:0]  q;
  logic [11:0] diff;
  logic [3:0]  r;
  logic        last_step;
  logic        nz_next;
  logic        done;

  always_comb begin
    v         = {rem, work[WREG_W-1 -: 8]};
    prod      = 24'(v) * 24'(RECIP10);
    q         = prod[RECIP_SHIFT +: 8];
    diff      = v - 12'(q) * 12'(TEN);
    r         = diff[3:0];
    last_step = (step == STEP_W'(BYTE_STEPS - 1));
    nz_next   = nz | (q != 8'd0);
    done      = busy && last_step &&
                (!nz_next || (count == CNT_W'(DIGIT_SLOTS - 1)));
  end

  assign push.valid = busy && last_step;
  assign push.digit = r;
  assign stat.done  = done;
  assign stat.count = count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work  <= WREG_W'(magnitude);
      rem   <= 4'd0;
      step  <= '0;
      nz    <= 1'b0;
      count <= '0;
    end else if (busy) begin
      work <= {work[WREG_W-9:0], q};
      if (last_step) begin
        step  <= '0;
        rem   <= 4'd0;
        nz    <= 1'b0;
        count <= count + 1'b1;
      end else begin
        step <= step + 1'b1;
        rem  <= r;
        nz   <= nz_next;
      end
    end
  end

endmodule

@@ hw/rtl/numdec_stack.sv @@
// ----------------------------------------------------------------------------
// numdec_stack
// Digit stack as a shift register: push moves every digit up one slot, pop
// moves them down, so the latest (most significant) digit is on top.
// ----------------------------------------------------------------------------
module numdec_stack import numdec_pkg::*; (
  input  logic        clk,
  input  digit_push_t push,
  input  logic        pop,
  output logic [3:0]  top_digit
);

  logic [3:0] slot [DIGIT_SLOTS];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot[0] <= push.digit;
      for (int i = 1; i < DIGIT_SLOTS; i++) begin
        slot[i] <= slot[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < DIGIT_SLOTS - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

  assign top_digit = slot[0];

endmodule

@@ hw/rtl/numdec_emit.sv @@
// ----------------------------------------------------------------------------
// numdec_emit
// Text sequencer: sends sign, leading "0.", zero padding, point and digits
// one character per cycle unless out_ready stalls, via a registered output.
// ----------------------------------------------------------------------------
module numdec_emit import numdec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  emit_cfg_t  cfg,
  input  logic [3:0] top_digit,
  output logic       pop,
  output logic       active,
  output logic       finish,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] text_char,
  output logic       last_char
);

  localparam logic [2:0] P_IDLE  = 3'd0;
  localparam logic [2:0] P_SIGN  = 3'd1;
  localparam logic [2:0] P_ZERO  = 3'd2;
  localparam logic [2:0] P_POINT = 3'd3;
  localparam logic [2:0] P_PAD   = 3'd4;
  localparam logic [2:0] P_DIGIT = 3'd5;

  logic [2:0]         phase;
  logic [CNT_W-1:0]   remaining;
  logic [SCALE_W-1:0] pad;
  logic [SCALE_W-1:0] scale;
  logic               dot_pending;
  logic               zero_lead;

  logic [2:0]         phase_next;
  logic [CNT_W-1:0]   remaining_next;
  logic [SCALE_W-1:0] pad_next;
  logic               dot_next;
  logic [6:0]         ch_next;
  logic               last_next;
  logic               advance;
  logic               dot_now;
  logic               start_lead;

  assign advance    = (phase != P_IDLE) && (!out_valid || out_ready);
  assign dot_now    = dot_pending && (remaining == CNT_W'(scale));
  assign start_lead = (7'(cfg.scale) >= 7'(cfg.count));
  assign active     = (phase != P_IDLE);
  assign finish     = advance && last_next;

  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    pad_next       = pad;
    dot_next       = dot_pending;
    ch_next        = CH_ZERO;
    last_next      = 1'b0;
    pop            = 1'b0;
    if (advance) begin
      unique case (phase)
        P_SIGN: begin
          ch_next    = CH_MINUS;
          phase_next = zero_lead ? P_ZERO : P_DIGIT;
        end
        P_ZERO: begin
          ch_next    = CH_ZERO;
          phase_next = P_POINT;
        end
        P_POINT: begin
          ch_next    = CH_POINT;
          phase_next = (pad != '0) ? P_PAD : P_DIGIT;
        end
        P_PAD: begin
          ch_next  = CH_ZERO;
          pad_next = pad - 1'b1;
          if (pad == SCALE_W'(1)) begin
            phase_next = P_DIGIT;
          end
        end
        P_DIGIT: begin
          if (dot_now) begin
            ch_next  = CH_POINT;
            dot_next = 1'b0;
          end else begin
            ch_next        = CH_ZERO + 7'(top_digit);
            pop            = 1'b1;
            remaining_next = remaining - 1'b1;
            if (remaining == CNT_W'(1)) begin
              last_next  = 1'b1;
              phase_next = P_IDLE;
            end
          end
        end
        default: begin
          phase_next = P_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= P_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cfg.start) begin
        phase <= cfg.negative ? P_SIGN : (start_lead ? P_ZERO : P_DIGIT);
      end else begin
        phase <= phase_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg.start) begin
      remaining   <= cfg.count;
      scale       <= cfg.scale;
      pad         <= cfg.scale - SCALE_W'(cfg.count);
      dot_pending <= !start_lead && (cfg.scale != '0);
      zero_lead   <= start_lead;
    end else begin
      remaining   <= remaining_next;
      pad         <= pad_next;
      dot_pending <= dot_next;
    end
    if (advance) begin
      text_char <= ch_next;
      last_char <= last_next;
    end
  end

endmodule

@@ hw/rtl/numeric128_to_decimal_text.sv @@
// The divide-by-ten stage takes one byte of the 128-bit value per cycle and
// yields one decimal digit per pass over all bytes; the digits then go to the
// emitter, which loads one character per cycle into the output register
// while out_ready allows. The next value is taken only once the last
// character is loaded into the output.
// Reset: synchronous, active high; clears the control state only.
// ----------------------------------------------------------------------------
// numeric128_to_decimal_text
// Converts a signed, scaled 128-bit magnitude into its decimal text, one
// ASCII character per output item with the last character flagged.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module numeric128_to_decimal_text import numdec_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [63:0]         magnitude_low,
  input  logic [63:0]         magnitude_high,
  input  logic                is_positive,
  input  logic [SCALE_W-1:0]  decimal_scale,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [6:0]          text_char,
  output logic                last_char
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state;
  logic [SCALE_W-1:0] scale;
  logic               negative;

  logic               accept;
  logic [127:0]       full_value;
  logic [SCALE_W-1:0] scale_sat;
  digit_push_t        push;
  div_stat_t          div_stat;
  emit_cfg_t          emit_cfg;
  logic [3:0]         top_digit;
  logic               pop;
  logic               emit_active;
  logic               emit_finish;

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign full_value = {magnitude_high, magnitude_low};
  assign scale_sat  = (decimal_scale > SCALE_W'(SCALE_MAX)) ? SCALE_W'(SCALE_MAX)
                                                            : decimal_scale;

  assign emit_cfg.start    = div_stat.done;
  assign emit_cfg.count    = div_stat.count;
  assign emit_cfg.scale    = scale;
  assign emit_cfg.negative = negative;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scale    <= scale_sat;
      negative <= !is_positive;
    end
  end

  numdec_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .magnitude (full_value[VALUE_BITS-1:0]),
    .push      (push),
    .stat      (div_stat)
  );

  numdec_stack u_stack (
    .clk       (clk),
    .push      (push),
    .pop       (pop),
    .top_digit (top_digit)
  );

  numdec_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .cfg       (emit_cfg),
    .top_digit (top_digit),
    .pop       (pop),
    .active    (emit_active),
    .finish    (emit_finish),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .text_char (text_char),
    .last_char (last_char)
  );

  `ASSERT_IMPL(a_idle_no_emit, clk, rst, state == ST_IDLE, !emit_active)
  `ASSERT_IMPL(a_done_in_div, clk, rst, div_stat.done, state == ST_DIV)
  `ASSERT_IMPL(a_count_range, clk, rst, div_stat.done,
               (div_stat.count != '0) && (div_stat.count <= CNT_W'(DIGIT_SLOTS)))
  `ASSERT_NEXT(a_accept_div, clk, rst, accept, state == ST_DIV)

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives signed, scaled 128-bit values into the decimal text converter and
// checks every emitted character and its last flag against an in-bench
// prediction of the text. The run covers directed edge values, then random
// values under varying sender idling and receiver stalls, including a long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top import numdec_pkg::*; ();

  localparam int HOLD_CYCLES    = 1200;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int TAIL_CYCLES    = 60;

  class text_scoreboard;
    typedef struct packed {
      logic [6:0] ch;
      logic       last;
    } text_item_t;

    text_item_t expected_text[$];
    int errors = 0;

    function void push_char(logic [6:0] ch);
      text_item_t item;
      item.ch = ch;
      item.last = 1'b0;
      expected_text.push_back(item);
    endfunction

    function void note_value(bit [127:0] mag, bit positive, bit [5:0] scale_field);
      bit [3:0]   digits[DIGIT_SLOTS];
      bit [127:0] quotient;
      int         count;
      int         scale;
      scale = (scale_field > SCALE_MAX) ? SCALE_MAX : int'(scale_field);
      quotient = mag;
      count = 0;
      do begin
        digits[count] = 4'(quotient % 10);
        quotient = quotient / 10;
        count++;
      end while (quotient != 0 && count < DIGIT_SLOTS);
      if (!positive) push_char(CH_MINUS);
      if (scale >= count) begin
        push_char(CH_ZERO);
        push_char(CH_POINT);
        for (int i = count; i < scale; i++) push_char(CH_ZERO);
        for (int i = count - 1; i >= 0; i--) push_char(CH_ZERO + 7'(digits[i]));
      end else begin
        for (int i = count - 1; i >= 0; i--) begin
          if (scale > 0 && i + 1 == scale) push_char(CH_POINT);
          push_char(CH_ZERO + 7'(digits[i]));
        end
      end
      expected_text[$].last = 1'b1;
    endfunction

    function void check_char(logic [6:0] ch, logic last);
      text_item_t want;
      if (expected_text.size() == 0) begin
        $display("%0t unexpected item: text_char %h last_char %b", $time, ch, last);
        errors++;
        return;
      end
      want = expected_text.pop_front();
      if (ch !== want.ch) begin
        $display("%0t text_char mismatch: expected %h actual %h", $time, want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t last_char mismatch: expected %b actual %b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [63:0]        magnitude_low = '0;
  logic [63:0]        magnitude_high = '0;
  logic               is_positive = 1'b1;
  logic [SCALE_W-1:0] decimal_scale = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [6:0]         text_char;
  logic               last_char;

  text_scoreboard sb = new();
  int         idle_pct = 0;
  int         stall_pct = 0;
  logic       hold_req = 1'b0;
  bit         hold_taken = 1'b0;
  int         quiet_cycles = 0;
  bit [127:0] pow10[39];

  numeric128_to_decimal_text DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .magnitude_low (magnitude_low),
    .magnitude_high(magnitude_high),
    .is_positive   (is_positive),
    .decimal_scale (decimal_scale),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .text_char     (text_char),
    .last_char     (last_char)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_char(text_char, last_char);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_value(bit [127:0] mag, bit positive, bit [5:0] scale);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    magnitude_low  <= mag[63:0];
    magnitude_high <= mag[127:64];
    is_positive    <= positive;
    decimal_scale  <= scale;
    do @(posedge clk); while (!in_ready);
    sb.note_value(mag, positive, scale);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_text.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(int count);
    bit [127:0] mag;
    bit [5:0]   scale;
    int         width;
    repeat (count) begin
      case ($urandom_range(5))
        0: mag = '0;
        1: mag = 128'($urandom_range(999));
        2: mag = {64'd0, $urandom, $urandom};
        3: mag = {$urandom, $urandom, $urandom, $urandom};
        4: begin
          width = $urandom_range(1, 128);
          mag = {$urandom, $urandom, $urandom, $urandom} >> (128 - width);
        end
        default: mag = pow10[$urandom_range(38)] + $urandom_range(2) - 1;
      endcase
      case ($urandom_range(3))
        0, 1: scale = 6'($urandom_range(38));
        2: scale = 6'($urandom_range(12));
        default: scale = 6'($urandom_range(63));
      endcase
      send_value(mag, 1'($urandom_range(1)), scale);
    end
  endtask

  initial begin
    pow10[0] = 1;
    for (int i = 1; i < 39; i++) pow10[i] = pow10[i-1] * 10;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_value('0, 1'b1, 6'd0);
    send_value('0, 1'b0, 6'd0);
    send_value('0, 1'b0, 6'd3);
    send_value('1, 1'b1, 6'd0);
    send_value('1, 1'b0, 6'd38);
    send_value('1, 1'b0, 6'd63);
    send_value(128'd1, 1'b0, 6'd38);
    send_value(128'd12345, 1'b1, 6'd5);
    send_value(128'd12345, 1'b0, 6'd4);
    send_value(128'd12345, 1'b1, 6'd6);
    send_value(128'd9, 1'b1, 6'd1);
    send_value(128'd10, 1'b0, 6'd1);
    send_value({64'd0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, 6'd20);
    send_value({64'd1, 64'd0}, 1'b1, 6'd19);
    send_value({64'hFFFF_FFFF_FFFF_FFFF, 64'd0}, 1'b0, 6'd37);
    send_value(pow10[38], 1'b1, 6'd38);
    send_value(pow10[38] - 1, 1'b0, 6'd38);
    send_value(128'd7, 1'b1, 6'd39);
    send_value(128'd42, 1'b0, 6'd40);
    send_value({4{32'hAAAA_AAAA}}, 1'b1, 6'd2);
    send_value({4{32'h5555_5555}}, 1'b0, 6'd32);
    wait_drained();

    send_random(35);
    wait_drained();

    idle_pct = 77;
    send_random(35);
    wait_drained();

    idle_pct = 0;
    stall_pct = 77;
    hold_req <= 1'b1;
    send_random(35);
    wait_drained();

    idle_pct = 35;
    stall_pct = 35;
    send_random(35);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ numeric128_to_decimal_text.f @@
+incdir+hw/rtl
hw/rtl/numdec_pkg.sv
hw/rtl/numdec_div.sv
hw/rtl/numdec_stack.sv
hw/rtl/numdec_emit.sv
hw/rtl/numeric128_to_decimal_text.sv
test/tb_top.sv
